### sv/symbol_floor_lookup_defines.svh
// ----------------------------------------------------------------------------
// Symbol floor lookup assertion macros
// Shared concurrent assertion forms, clocked on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_FLOOR_LOOKUP_DEFINES_SVH
`define SYMBOL_FLOOR_LOOKUP_DEFINES_SVH

// check cons in the same cycle as ant
`define SFL_ASSERT_SAME(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ant
`define SFL_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

### sv/sfl_pkg.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup package
// Field widths, request and status codes, and the types shared by the modules.
// ----------------------------------------------------------------------------
package sfl_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int NAME_W     = 32;
   localparam int INFO_W     = 8;
   localparam int SYM_TYPE_W = 4;
   localparam int ADDR_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 32;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_HIT  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd3;

   localparam logic [SYM_TYPE_W-1:0] SYM_TYPE_FUNC = 4'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]     start;
      logic [NAME_W-1:0]     name_index;
      logic [SYM_TYPE_W-1:0] sym_type;
   } entry_type;

   typedef struct packed {
      logic clr;
      logic eval;
   } scan_ctl_type;

   typedef struct packed {
      logic              found;
      logic [NAME_W-1:0] name_index;
      logic [ADDR_W-1:0] offset;
   } scan_res_type;

endpackage

### sv/sfl_req_if.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sfl_req_if;
   import sfl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [NAME_W-1:0]     entry_name_index;
   logic [INFO_W-1:0]     entry_info;
   logic [ADDR_W-1:0]     entry_start;
   logic [ADDR_W-1:0]     query_addr;

   modport source (
      output valid, req_type, entry_name_index, entry_info, entry_start, query_addr,
      input  ready
   );

   modport sink (
      input  valid, req_type, entry_name_index, entry_info, entry_start, query_addr,
      output ready
   );

endinterface

### sv/sfl_rsp_if.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sfl_rsp_if;
   import sfl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NAME_W-1:0]   match_name_index;
   logic [ADDR_W-1:0]   match_offset;

   modport source (
      output valid, status, match_name_index, match_offset,
      input  ready
   );

   modport sink (
      input  valid, status, match_name_index, match_offset,
      output ready
   );

endinterface

### sv/sfl_cell.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup table cell
// Holds one symbol entry; takes a loaded entry or its neighbor's on a shift.
// ----------------------------------------------------------------------------
module sfl_cell (
   input  logic               clock,
   input  logic               shift,
   input  logic               wr,
   input  sfl_pkg::entry_type load_entry,
   input  sfl_pkg::entry_type neighbor,
   output sfl_pkg::entry_type entry
);
   import sfl_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (wr) begin
         entry_in = load_entry;
      end else if (shift) begin
         entry_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### sv/sfl_scan.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup scan unit
// Judges the entry at the head of the ring and keeps the best candidate.
// ----------------------------------------------------------------------------
module sfl_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  sfl_pkg::scan_ctl_type        ctl,
   input  logic [sfl_pkg::ADDR_W-1:0]   query_addr,
   input  logic [sfl_pkg::CFG_W-1:0]    str_tab_len,
   input  sfl_pkg::entry_type           head,
   output sfl_pkg::scan_res_type        res
);
   import sfl_pkg::*;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in;
   logic [NAME_W-1:0] best_name_ff, best_name_in;
   logic              eligible;
   logic              better;

   assign eligible = (head.name_index != '0) && (head.name_index < str_tab_len)
                     && (head.sym_type == SYM_TYPE_FUNC);
   assign better   = !found_ff || (best_start_ff < head.start);

   always_comb begin
      addr_in       = addr_ff;
      found_in      = found_ff;
      best_start_in = best_start_ff;
      best_name_in  = best_name_ff;
      if (ctl.clr) begin
         addr_in  = query_addr;
         found_in = 1'b0;
      end else if (ctl.eval && eligible && (head.start <= addr_ff) && better) begin
         found_in      = 1'b1;
         best_start_in = head.start;
         best_name_in  = head.name_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      best_start_ff <= best_start_in;
      best_name_ff  <= best_name_in;
   end

   assign res.found      = found_ff;
   assign res.name_index = best_name_ff;
   assign res.offset     = addr_ff - best_start_ff;

endmodule

### sv/symbol_floor_lookup.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup
// Symbol table that resolves an address to its enclosing function symbol.
// ----------------------------------------------------------------------------
// The table is a ring of MAX_SYMBOLS cells, one entry each, with a single
// compare unit watching the head cell. A load or clear moves to ST_SEND, which
// registers the result. A query rotates the ring one full turn in ST_SCAN, one
// cell per cycle, whatever the fill level, forms the offset in ST_FINISH and
// registers it in ST_SEND. One request is in flight at a time; a request is
// taken while the previous result still waits at the output. No clearing pass
// runs after reset; entries beyond the fill count are never judged.
module symbol_floor_lookup #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   sfl_req_if.sink                      req,
   sfl_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [sfl_pkg::CFG_W-1:0]    csr_wdata
);
   import sfl_pkg::*;

   localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_SEND   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [CFG_W-1:0]    stl_ff, stl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [NAME_W-1:0]   pend_name_ff, pend_name_in;
   logic [ADDR_W-1:0]   pend_off_ff, pend_off_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NAME_W-1:0]   rsp_name_ff, rsp_name_in;
   logic [ADDR_W-1:0]   rsp_off_ff, rsp_off_in;

   logic                accept;
   logic                is_load;
   logic                shift;
   logic                out_free;
   scan_ctl_type        scan_ctl;
   scan_res_type        scan_res;
   entry_type           load_entry;
   entry_type           cell_q [MAX_SYMBOLS];

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_load   = accept && (req.req_type == REQ_LOAD);
   assign shift     = (state_ff == ST_SCAN);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign load_entry.start      = req.entry_start;
   assign load_entry.name_index = req.entry_name_index;
   assign load_entry.sym_type   = req.entry_info[SYM_TYPE_W-1:0];

   assign scan_ctl.clr  = accept && (req.req_type == REQ_QUERY);
   assign scan_ctl.eval = shift && (CNT_W'(step_ff) < count_ff);

   // ring: each cell hands its entry toward the head; the head wraps to the tail
   for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
      localparam int NEXT = (i == MAX_SYMBOLS - 1) ? 0 : i + 1;
      sfl_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .wr         (is_load && (count_ff == CNT_W'(i))),
         .load_entry (load_entry),
         .neighbor   (cell_q[NEXT]),
         .entry      (cell_q[i])
      );
   end

   sfl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .query_addr  (req.query_addr),
      .str_tab_len (stl_ff),
      .head        (cell_q[0]),
      .res         (scan_res)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      stl_in         = csr_we ? csr_wdata : stl_ff;
      rsp_valid_in   = rsp_valid_ff;
      pend_status_in = pend_status_ff;
      pend_name_in   = pend_name_ff;
      pend_off_in    = pend_off_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_name_in    = rsp_name_ff;
      rsp_off_in     = rsp_off_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_status_in = STAT_OK;
               pend_name_in   = '0;
               pend_off_in    = '0;
               state_in       = ST_SEND;
               case (req.req_type)
                  REQ_LOAD: begin
                     if (count_ff < CNT_W'(MAX_SYMBOLS)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        pend_status_in = STAT_FULL;
                     end
                  end
                  REQ_QUERY: begin
                     step_in  = '0;
                     state_in = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(MAX_SYMBOLS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            pend_status_in = scan_res.found ? STAT_HIT : STAT_MISS;
            pend_name_in   = scan_res.found ? scan_res.name_index : '0;
            pend_off_in    = scan_res.found ? scan_res.offset : '0;
            state_in       = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_name_in   = pend_name_ff;
               rsp_off_in    = pend_off_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         stl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         stl_ff       <= stl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_name_ff   <= pend_name_in;
      pend_off_ff    <= pend_off_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_name_ff    <= rsp_name_in;
      rsp_off_ff     <= rsp_off_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.match_name_index = rsp_name_ff;
   assign rsp.match_offset     = rsp_off_ff;

endmodule

### sv/sfl_checker.sv
// ----------------------------------------------------------------------------
// Symbol floor lookup port checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "symbol_floor_lookup_defines.svh"

module sfl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [sfl_pkg::REQ_TYPE_W-1:0] req_type,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sfl_pkg::STATUS_W-1:0]   rsp_status,
   input logic [sfl_pkg::NAME_W-1:0]     rsp_match_name_index,
   input logic [sfl_pkg::ADDR_W-1:0]     rsp_match_offset
);
   import sfl_pkg::*;

   `SFL_ASSERT_SAME(a_nohit_zero, rsp_valid && (rsp_status != STAT_HIT), (rsp_match_name_index == '0) && (rsp_match_offset == '0), "non-hit item carries nonzero match fields")
   `SFL_ASSERT_SAME(a_hit_named, rsp_valid && (rsp_status == STAT_HIT), rsp_match_name_index != '0, "hit item has an unnamed symbol")
   `SFL_ASSERT_NEXT(a_query_busy, req_valid && req_ready && (req_type == REQ_QUERY), !req_ready, "request taken while a query scans")
   `SFL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_match_offset), "stalled result item changed")

endmodule

bind symbol_floor_lookup sfl_checker u_sfl_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .req_type             (req.req_type),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_status           (rsp.status),
   .rsp_match_name_index (rsp.match_name_index),
   .rsp_match_offset     (rsp.match_offset)
);
